### src/md5sh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round functions for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned DataWords  = 14;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Lanes      = 4;
  localparam int unsigned WordAw     = $clog2(BlockWords);
  localparam int unsigned ByteAw     = $clog2(BlockBytes);

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  // How the message words of the current block are formed
  typedef enum logic [1:0] {
    BLK_DATA,    // all bytes from the buffer
    BLK_PAD,     // buffer bytes, 0x80, zeros; no length
    BLK_PADLEN,  // buffer bytes, 0x80, zeros, bit length in last two words
    BLK_LEN      // zeros and bit length
  } blk_mode_e;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word index used by round r
  function automatic logic [WordAw-1:0] msg_idx(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = r4 * 4'd5 + 4'd1;
      2'd2:    g = r4 * 4'd3 + 4'd5;
      default: g = r4 * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage
`default_nettype wire

### src/md5sh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5sh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### src/md5_stream_hasher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_hasher_top
// MD5 digest over a byte stream, one byte item at a time.
// ----------------------------------------------------------------------------
// A byte that does not complete a block is written to the buffer RAM. A byte
// that completes a block starts a compression: load, 64 rounds through the
// shared round adder (a sum half, then a rotate/add half), fold. A last item
// adds one or two padding blocks, then the digest sits in the output register.
// Throughput: 1 item per cycle inside a block; none while compressing or in ST_OUT.
// Reset: chaining words to the MD5 initial values, byte count to zero; the
// block buffer RAM is not cleared (only written bytes are ever used).
// ----------------------------------------------------------------------------
module md5_stream_hasher_top
  import md5sh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] digest_a_o,
  output logic      [31:0] digest_b_o,
  output logic      [31:0] digest_c_o,
  output logic      [31:0] digest_d_o
);

  // Control state
  state_e      state_q, state_d;
  blk_mode_e   mode_q, mode_d;
  logic        last_q, last_d;
  logic        sub_q, sub_d;         // half of a round: 0 sum, 1 rotate/add
  logic [5:0]  rnd_q, rnd_d;
  logic [60:0] count_q, count_d;     // message length in bytes
  logic [3:0][31:0] chain_q, chain_d;

  // Datapath state (no reset)
  logic [3:0][31:0] work_q, work_d;  // A..D during compression
  logic [31:0]      sum_q, sum_d;
  logic [3:0][31:0] dig_q, dig_d;

  // Buffer RAM, one byte lane per instance
  logic [Lanes-1:0]  ram_we;
  logic [WordAw-1:0] ram_raddr;
  logic [Lanes-1:0][7:0] ram_rdata;
  logic [ByteAw-1:0] wr_pos;

  logic        in_acc, out_acc;
  logic [60:0] count_inc;
  logic [5:0]  addr_rnd;
  logic [WordAw-1:0] g_cur;
  logic [31:0] msg_word;
  logic [63:0] bit_len;
  logic [5:0]  pad_pos;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  assign digest_a_o = dig_q[0];
  assign digest_b_o = dig_q[1];
  assign digest_c_o = dig_q[2];
  assign digest_d_o = dig_q[3];

  assign wr_pos    = count_q[ByteAw-1:0];
  assign count_inc = count_q + 61'd1;
  assign bit_len   = {count_q, 3'b000};
  assign pad_pos   = count_q[5:0];

  // Read address runs one round ahead: issued in the rotate half (or in load)
  // so data is ready for the sum half of the next round.
  assign addr_rnd  = (state_q == ST_LOAD) ? 6'd0 : (sub_q ? rnd_q + 6'd1 : rnd_q);
  assign ram_raddr = msg_idx(addr_rnd);
  assign g_cur     = msg_idx(rnd_q);

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    assign ram_we[l] = in_acc & has_byte_i & (wr_pos[1:0] == 2'(l));
    md5sh_ram #(
      .Width(8),
      .Depth(BlockWords)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[l]),
      .waddr_i(wr_pos[ByteAw-1:2]),
      .wdata_i(data_byte_i),
      .raddr_i(ram_raddr),
      .rdata_o(ram_rdata[l])
    );
  end

  // Message word: buffer bytes with padding and length laid over them;
  // the length-only block carries no buffer bytes at all
  always_comb begin
    logic [5:0] bidx;
    logic [7:0] bval;
    msg_word = '0;
    for (int k = 0; k < Lanes; k++) begin
      bidx = {g_cur, 2'(k)};
      if (mode_q == BLK_DATA || (mode_q != BLK_LEN && bidx < pad_pos)) begin
        bval = ram_rdata[k];
      end else if (bidx == pad_pos && mode_q != BLK_LEN) begin
        bval = PadByte;
      end else begin
        bval = 8'h00;
      end
      msg_word[8*k +: 8] = bval;
    end
    if (mode_q == BLK_PADLEN || mode_q == BLK_LEN) begin
      if (g_cur == WordAw'(DataWords)) begin
        msg_word = bit_len[31:0];
      end else if (g_cur == WordAw'(DataWords + 1)) begin
        msg_word = bit_len[63:32];
      end
    end
  end

  // Sequencer and shared round unit
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    last_d  = last_q;
    sub_d   = sub_q;
    rnd_d   = rnd_q;
    count_d = count_q;
    chain_d = chain_q;
    work_d  = work_q;
    sum_d   = sum_q;
    dig_d   = dig_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          last_d = is_last_i;
          if (has_byte_i) begin
            count_d = count_inc;
          end
          if (has_byte_i && wr_pos == ByteAw'(BlockBytes - 1)) begin
            mode_d  = BLK_DATA;
            state_d = ST_LOAD;
          end else if (is_last_i) begin
            mode_d  = ((has_byte_i ? count_inc[5:0] : pad_pos) >= 6'(LenOffset)) ?
                      BLK_PAD : BLK_PADLEN;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        work_d  = chain_q;
        rnd_d   = 6'd0;
        sub_d   = 1'b0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (!sub_q) begin
          sum_d = work_q[0] + round_f(rnd_q[5:4], work_q[1], work_q[2], work_q[3]) +
                  msg_word + sine_k(rnd_q);
          sub_d = 1'b1;
        end else begin
          work_d[0] = work_q[3];
          work_d[3] = work_q[2];
          work_d[2] = work_q[1];
          work_d[1] = work_q[1] + rotl(sum_q, rot_amt(rnd_q));
          sub_d     = 1'b0;
          rnd_d     = rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_d = ST_FOLD;
          end
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 4; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        case (mode_q)
          BLK_DATA: begin
            if (last_q) begin
              // block just closed, so padding starts at byte zero
              mode_d  = BLK_PADLEN;
              state_d = ST_LOAD;
            end else begin
              state_d = ST_IDLE;
            end
          end
          BLK_PAD: begin
            mode_d  = BLK_LEN;
            state_d = ST_LOAD;
          end
          default: begin
            dig_d   = chain_d;
            chain_d = {InitD, InitC, InitB, InitA};
            count_d = '0;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= BLK_DATA;
      last_q  <= 1'b0;
      sub_q   <= 1'b0;
      rnd_q   <= 6'd0;
      count_q <= '0;
      chain_q <= {InitD, InitC, InitB, InitA};
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      last_q  <= last_d;
      sub_q   <= sub_d;
      rnd_q   <= rnd_d;
      count_q <= count_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    sum_q  <= sum_d;
    dig_q  <= dig_d;
  end

endmodule
`default_nettype wire
